// File: hdl/renc_pkg.sv
`timescale 1ns / 1ps

package renc_pkg;

  // request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_VALUE  = 2'd1;
  localparam logic [1:0] REQ_BUTTON = 2'd2;

  // decoder modes; the unused code decodes as gray
  localparam logic [1:0] MODE_GRAY = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;

  // steps per notch codes that scale
  localparam logic [2:0] SPN_TWO  = 3'd2;
  localparam logic [2:0] SPN_FOUR = 3'd4;

  // register indexes
  localparam logic [2:0] REG_DECODER_MODE    = 3'd0;
  localparam logic [2:0] REG_STEPS_PER_NOTCH = 3'd1;
  localparam logic [2:0] REG_ACTIVE_LEVEL    = 3'd2;
  localparam logic [2:0] REG_ACCEL_ENABLE    = 3'd3;
  localparam logic [2:0] REG_DC_ENABLE       = 3'd4;
  localparam logic [2:0] REG_HELD_ENABLE     = 3'd5;
  localparam logic [2:0] REG_HOLD_LIMIT      = 3'd6;
  localparam logic [2:0] REG_DC_WINDOW       = 3'd7;

  // button status codes
  localparam logic [2:0] BTN_OPEN     = 3'd0;
  localparam logic [2:0] BTN_HELD     = 3'd1;
  localparam logic [2:0] BTN_RELEASED = 3'd2;
  localparam logic [2:0] BTN_CLICKED  = 3'd3;
  localparam logic [2:0] BTN_DOUBLE   = 3'd4;

  // acceleration
  localparam logic [10:0] ACCEL_TOP = 11'd2000;
  localparam logic [10:0] ACCEL_INC = 11'd20;
  localparam logic [10:0] ACCEL_DEC = 11'd2;

  typedef struct packed {
    logic       move;
    logic       up;
  } dir_t;

  // hold_checks and dc_checks are already divided by the button interval
  typedef struct packed {
    logic [1:0]  decoder_mode;
    logic [2:0]  steps_per_notch;
    logic        active_level;
    logic        accel_enable;
    logic        dc_enable;
    logic        held_enable;
    logic [15:0] hold_checks;
    logic [9:0]  dc_checks;
  } cfg_t;

  // full step transition table, index {old a, old b, new a, new b}
  function automatic dir_t full_step_dir(input logic [3:0] idx);
    dir_t d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = '{move: 1'b1, up: 1'b1};
      4'd2, 4'd4, 4'd11, 4'd13: d = '{move: 1'b1, up: 1'b0};
      default:                  d = '{move: 1'b0, up: 1'b0};
    endcase
    return d;
  endfunction

  // half step transition table
  function automatic dir_t half_step_dir(input logic [3:0] idx);
    dir_t d;
    case (idx)
      4'd7, 4'd8:  d = '{move: 1'b1, up: 1'b1};
      4'd2, 4'd13: d = '{move: 1'b1, up: 1'b0};
      default:     d = '{move: 1'b0, up: 1'b0};
    endcase
    return d;
  endfunction

endpackage

// File: hdl/renc_if.sv
`timescale 1ns / 1ps

interface renc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       pin_a;
  logic       pin_b;
  logic       button_level;

  modport source (output valid, req_type, pin_a, pin_b, button_level, input ready);
  modport sink (input valid, req_type, pin_a, pin_b, button_level, output ready);
endinterface

interface renc_result_if;
  logic              valid;
  logic              ready;
  logic signed [4:0] rotation_value;
  logic [2:0]        button_status;

  modport source (output valid, rotation_value, button_status, input ready);
  modport sink (input valid, rotation_value, button_status, output ready);
endinterface

interface renc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/rotary_encoder_accel_button.sv
`timescale 1ns / 1ps

// channel  dir  signals
// item     in   valid/ready, req_type, pin_a, pin_b, button_level
// result   out  valid/ready, rotation_value, button_status
// cfg      in   valid/ready, index, data (ready is always high)
//
// One word per cycle while no read stalls: each word is registered, then
// handled against decoder and button state; a read loads the result register.
// A read's result word is held in the result register until it is taken.
// Ticks give no result and never wait; a read waits only while the result
// register holds a word not yet taken, and then the input stage holds too.
// Reset is synchronous; all but the data registers take their defaults.

module rotary_encoder_accel_button #(
  parameter int BUTTON_INTERVAL = 10
) (
  input  logic         clk,
  input  logic         rst,
  renc_item_if.sink    item,
  renc_result_if.source result,
  renc_cfg_if.sink     cfg
);

  renc_pkg::cfg_t regs;

  // input register
  logic       in_v;
  logic [1:0] in_req;
  logic       in_a;
  logic       in_b;
  logic       in_btn;

  // result register
  logic              out_v;
  logic signed [4:0] out_rot;
  logic [2:0]        out_stat;

  logic              has_result;
  logic              out_free;
  logic              fire;
  logic              tick_en;
  logic              value_rd;
  logic              button_rd;
  logic signed [4:0] rot_val;
  logic [2:0]        btn_stat;

  // a read needs the result register; ticks and unused codes just drain
  assign has_result = (in_req == renc_pkg::REQ_VALUE) || (in_req == renc_pkg::REQ_BUTTON);
  assign out_free   = !out_v || result.ready;
  assign fire       = in_v && (!has_result || out_free);
  assign item.ready = !in_v || fire;

  assign tick_en   = fire && (in_req == renc_pkg::REQ_TICK);
  assign value_rd  = fire && (in_req == renc_pkg::REQ_VALUE);
  assign button_rd = fire && (in_req == renc_pkg::REQ_BUTTON);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_v <= 1'b1;
    end else if (fire) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_req <= item.req_type;
      in_a   <= item.pin_a;
      in_b   <= item.pin_b;
      in_btn <= item.button_level;
    end
  end

  renc_cfg #(
    .BUTTON_INTERVAL(BUTTON_INTERVAL)
  ) u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  renc_quad u_quad (
    .clk            (clk),
    .rst            (rst),
    .cfg            (regs),
    .tick_en        (tick_en),
    .read_en        (value_rd),
    .pin_a          (in_a),
    .pin_b          (in_b),
    .rotation_value (rot_val)
  );

  renc_btn #(
    .BUTTON_INTERVAL(BUTTON_INTERVAL)
  ) u_btn (
    .clk           (clk),
    .rst           (rst),
    .cfg           (regs),
    .tick_en       (tick_en),
    .read_en       (button_rd),
    .button_level  (in_btn),
    .button_status (btn_stat)
  );

  // result register: value read zeroes the status, button read the value
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (value_rd || button_rd) begin
      out_v <= 1'b1;
    end else if (result.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (value_rd) begin
      out_rot  <= rot_val;
      out_stat <= renc_pkg::BTN_OPEN;
    end else if (button_rd) begin
      out_rot  <= 5'sd0;
      out_stat <= btn_stat;
    end
  end

  assign result.valid          = out_v;
  assign result.rotation_value = out_rot;
  assign result.button_status  = out_stat;

  a_read_loads: assert property (@(posedge clk) disable iff (rst)
    (value_rd || button_rd) |=> out_v)
    else $error("read handled but no result word");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (in_v && has_result && out_v && !result.ready) |-> !item.ready)
    else $error("input taken while a read is stalled");

endmodule

// File: hdl/renc_cfg.sv
`timescale 1ns / 1ps

module renc_cfg #(
  parameter int BUTTON_INTERVAL = 10
) (
  input  logic            clk,
  input  logic            rst,
  renc_cfg_if.sink        cfg,
  output renc_pkg::cfg_t  regs
);

  // divide by the interval through a reciprocal, exact for 16-bit operands
  localparam int          SHIFT = 20;
  localparam logic [20:0] RECIP = 21'(((1 << SHIFT) + BUTTON_INTERVAL - 1) / BUTTON_INTERVAL);
  localparam logic [15:0] HOLD_RESET = 16'(100 / BUTTON_INTERVAL);
  localparam logic [9:0]  DC_RESET   = 10'(60 / BUTTON_INTERVAL);

  logic [15:0] div_in;
  logic [36:0] div_prod;
  logic [15:0] div_q;
  logic        wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;

  always_comb begin
    div_in = (cfg.index == renc_pkg::REG_HOLD_LIMIT) ? cfg.data : {6'b0, cfg.data[9:0]};
    div_prod = {21'b0, div_in} * {16'b0, RECIP};
    div_q = div_prod[35:20];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.decoder_mode    <= renc_pkg::MODE_GRAY;
      regs.steps_per_notch <= 3'd1;
      regs.active_level    <= 1'b0;
      regs.accel_enable    <= 1'b1;
      regs.dc_enable       <= 1'b1;
      regs.held_enable     <= 1'b1;
      regs.hold_checks     <= HOLD_RESET;
      regs.dc_checks       <= DC_RESET;
    end else if (wr) begin
      unique case (cfg.index)
        renc_pkg::REG_DECODER_MODE:    regs.decoder_mode    <= cfg.data[1:0];
        renc_pkg::REG_STEPS_PER_NOTCH: regs.steps_per_notch <= cfg.data[2:0];
        renc_pkg::REG_ACTIVE_LEVEL:    regs.active_level    <= cfg.data[0];
        renc_pkg::REG_ACCEL_ENABLE:    regs.accel_enable    <= cfg.data[0];
        renc_pkg::REG_DC_ENABLE:       regs.dc_enable       <= cfg.data[0];
        renc_pkg::REG_HELD_ENABLE:     regs.held_enable     <= cfg.data[0];
        renc_pkg::REG_HOLD_LIMIT:      regs.hold_checks     <= div_q;
        renc_pkg::REG_DC_WINDOW:       regs.dc_checks       <= div_q[9:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/renc_quad.sv
`timescale 1ns / 1ps

module renc_quad (
  input  logic              clk,
  input  logic              rst,
  input  renc_pkg::cfg_t    cfg,
  input  logic              tick_en,
  input  logic              read_en,
  input  logic              pin_a,
  input  logic              pin_b,
  output logic signed [4:0] rotation_value
);

  logic [3:0]  prev_phase;
  logic [15:0] step_count;
  logic [10:0] accel_level;

  logic          a_on, b_on;
  logic [3:0]    tab_idx;
  logic [1:0]    gray_cur, gray_diff;
  renc_pkg::dir_t dir;
  logic [3:0]    phase_next;
  logic [15:0]   count_step;
  logic [10:0]   accel_decay, accel_tick;
  logic [15:0]   count_keep;
  logic          nonzero;
  logic [4:0]    mag;

  always_comb begin
    a_on      = ~(pin_a ^ cfg.active_level);
    b_on      = ~(pin_b ^ cfg.active_level);
    tab_idx   = {prev_phase[1:0], a_on, b_on};
    gray_cur  = {a_on, a_on ^ b_on};
    gray_diff = prev_phase[1:0] - gray_cur;

    unique case (cfg.decoder_mode)
      renc_pkg::MODE_FULL: begin
        dir        = renc_pkg::full_step_dir(tab_idx);
        phase_next = tab_idx;
      end
      renc_pkg::MODE_HALF: begin
        dir        = renc_pkg::half_step_dir(tab_idx);
        phase_next = tab_idx;
      end
      default: begin
        // gray rule: odd difference is a move, bit 1 gives direction
        dir.move   = gray_diff[0];
        dir.up     = gray_diff[1];
        phase_next = gray_diff[0] ? {2'b00, gray_cur} : prev_phase;
      end
    endcase

    count_step  = dir.up ? step_count + 16'd1 : step_count - 16'd1;
    accel_decay = (accel_level >= renc_pkg::ACCEL_DEC) ? accel_level - renc_pkg::ACCEL_DEC
                                                      : 11'd0;
    accel_tick  = (dir.move && accel_decay <= renc_pkg::ACCEL_TOP - renc_pkg::ACCEL_INC)
                  ? accel_decay + renc_pkg::ACCEL_INC : accel_decay;

    // value read: keep the sub-notch remainder
    case (cfg.steps_per_notch)
      renc_pkg::SPN_TWO: begin
        count_keep = {15'b0, step_count[0]};
        nonzero    = |step_count[15:1];
      end
      renc_pkg::SPN_FOUR: begin
        count_keep = {14'b0, step_count[1:0]};
        nonzero    = |step_count[15:2];
      end
      default: begin
        count_keep = 16'd0;
        nonzero    = |step_count;
      end
    endcase

    mag = 5'd1 + (cfg.accel_enable ? {2'b00, accel_level[10:8]} : 5'd0);
    if (step_count[15]) begin
      rotation_value = $signed(5'd0 - mag);
    end else if (nonzero) begin
      rotation_value = $signed(mag);
    end else begin
      rotation_value = 5'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phase  <= 4'd0;
      step_count  <= 16'd0;
      accel_level <= 11'd0;
    end else if (tick_en) begin
      prev_phase <= phase_next;
      if (dir.move) begin
        step_count <= count_step;
      end
      if (cfg.accel_enable) begin
        accel_level <= accel_tick;
      end
    end else if (read_en) begin
      step_count <= count_keep;
    end
  end

  a_accel_bound: assert property (@(posedge clk) disable iff (rst)
    accel_level <= renc_pkg::ACCEL_TOP)
    else $error("acceleration level above its ceiling");

endmodule

// File: hdl/renc_btn.sv
`timescale 1ns / 1ps

module renc_btn #(
  parameter int BUTTON_INTERVAL = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  renc_pkg::cfg_t cfg,
  input  logic           tick_en,
  input  logic           read_en,
  input  logic           button_level,
  output logic [2:0]     button_status
);

  localparam logic [3:0] INTERVAL = 4'(BUTTON_INTERVAL);

  logic [3:0]  interval_count;
  logic [15:0] press_count;
  logic [9:0]  click_window;
  logic [2:0]  button_state;

  logic [3:0]  interval_inc;
  logic        check;
  logic        pressed;
  logic [15:0] press_next;
  logic [9:0]  window_mid;
  logic [9:0]  window_next;
  logic [2:0]  state_next;

  assign button_status = button_state;

  always_comb begin
    interval_inc = interval_count + 4'd1;
    check        = interval_inc >= INTERVAL;
    pressed      = ~(button_level ^ cfg.active_level);
    press_next   = press_count;
    window_mid   = click_window;
    state_next   = button_state;

    if (pressed) begin
      if (press_count != 16'hFFFF) begin
        press_next = press_count + 16'd1;
      end
      if (press_next > cfg.hold_checks && cfg.held_enable) begin
        state_next = renc_pkg::BTN_HELD;
      end
    end else begin
      if (press_count > 16'd1) begin
        if (button_state == renc_pkg::BTN_HELD) begin
          state_next = renc_pkg::BTN_RELEASED;
          window_mid = 10'd0;
        end else if (click_window > 10'd1) begin
          if (click_window < cfg.dc_checks) begin
            state_next = renc_pkg::BTN_DOUBLE;
            window_mid = 10'd0;
          end
        end else begin
          window_mid = cfg.dc_enable ? cfg.dc_checks : 10'd1;
        end
      end
      press_next = 16'd0;
    end

    window_next = window_mid;
    if (window_mid != 10'd0) begin
      window_next = window_mid - 10'd1;
      if (window_next == 10'd0) begin
        state_next = renc_pkg::BTN_CLICKED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_count <= 4'd0;
      press_count    <= 16'd0;
      click_window   <= 10'd0;
      button_state   <= renc_pkg::BTN_OPEN;
    end else if (tick_en) begin
      if (check) begin
        interval_count <= 4'd0;
        press_count    <= press_next;
        click_window   <= window_next;
        button_state   <= state_next;
      end else begin
        interval_count <= interval_inc;
      end
    end else if (read_en) begin
      if (button_state != renc_pkg::BTN_HELD && button_state != renc_pkg::BTN_OPEN) begin
        button_state <= renc_pkg::BTN_OPEN;
      end
    end
  end

  a_interval_bound: assert property (@(posedge clk) disable iff (rst)
    interval_count < INTERVAL)
    else $error("interval counter past the button interval");

  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    (read_en && button_state != renc_pkg::BTN_HELD) |=> button_state == renc_pkg::BTN_OPEN)
    else $error("button read left a one-shot status set");

endmodule

// File: test/tb_rotary_encoder_accel_button.sv
`timescale 1ns / 1ps

module tb_rotary_encoder_accel_button;

  // codes the package leaves unnamed
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int BTN_IVL        = 10;
  localparam int RAND_PER_PHASE = 92;
  localparam int PHASES         = 8;
  localparam int HOG_PHASE      = 6;
  localparam int HOG_CYCLES     = 80;
  localparam int HOG_BURST      = 16;
  // two-stage pipeline plus margin: a tick may still be in flight after
  // the last read word has come out
  localparam int DRAIN_CYCLES   = 4;
  localparam int IDLE_LIMIT     = 2000;

  // transition tables, index {old a, old b, new a, new b}
  localparam int FULL_DIR [16] = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};
  localparam int HALF_DIR [16] = '{0, 0, -1, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, -1, 0, 0};

  typedef struct packed {
    logic signed [4:0] rotation;
    logic [2:0]        status;
  } renc_word_t;

  typedef struct packed {
    logic [1:0] req;
    logic       pin_a;
    logic       pin_b;
    logic       btn;
    logic       typed;   // word below is the expectation, else predicted
    renc_word_t word;
  } stim_row_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  spn;
    logic        act;
    logic        acc_en;
    logic        dc_en;
    logic        held_en;
    logic [15:0] hold;
    logic [9:0]  dcw;
  } phase_cfg_t;

  // Directed words, defaults after reset (gray, active low, accel on).
  // Pins idle high, so (1,1) is phase 0 and (1,0) one step up.
  localparam int STIM_ROWS = 17;
  localparam stim_row_t STIM_TAB [STIM_ROWS] = '{
    // value read and button read from reset, then an unused code (no word)
    '{renc_pkg::REQ_VALUE, 1'b1, 1'b1, 1'b1, 1'b1, '{5'sd0, renc_pkg::BTN_OPEN}},
    '{renc_pkg::REQ_BUTTON, 1'b1, 1'b1, 1'b1, 1'b1, '{5'sd0, renc_pkg::BTN_OPEN}},
    '{REQ_UNUSED, 1'b0, 1'b0, 1'b0, 1'b0, '{5'sd0, renc_pkg::BTN_OPEN}},
    // one step up, read
    '{renc_pkg::REQ_TICK, 1'b1, 1'b0, 1'b1, 1'b0, '{5'sd0, renc_pkg::BTN_OPEN}},
    '{renc_pkg::REQ_VALUE, 1'b0, 1'b0, 1'b0, 1'b1, '{5'sd1, renc_pkg::BTN_OPEN}},
    // one step down, count -1; negative reads as -1
    '{renc_pkg::REQ_TICK, 1'b1, 1'b1, 1'b1, 1'b0, '{5'sd0, renc_pkg::BTN_OPEN}},
    '{renc_pkg::REQ_VALUE, 1'b1, 1'b1, 1'b1, 1'b1, '{-5'sd1, renc_pkg::BTN_OPEN}},
    '{renc_pkg::REQ_TICK, 1'b0, 1'b1, 1'b1, 1'b0, '{5'sd0, renc_pkg::BTN_OPEN}},
    '{renc_pkg::REQ_TICK, 1'b0, 1'b0, 1'b1, 1'b0, '{5'sd0, renc_pkg::BTN_OPEN}},
    // two-phase jump, no move
    '{renc_pkg::REQ_TICK, 1'b1, 1'b1, 1'b1, 1'b0, '{5'sd0, renc_pkg::BTN_OPEN}},
    // button pressed
    '{renc_pkg::REQ_TICK, 1'b1, 1'b0, 1'b0, 1'b0, '{5'sd0, renc_pkg::BTN_OPEN}},
    '{renc_pkg::REQ_VALUE, 1'b0, 1'b1, 1'b0, 1'b0, '{5'sd0, renc_pkg::BTN_OPEN}},
    '{renc_pkg::REQ_BUTTON, 1'b1, 1'b0, 1'b0, 1'b0, '{5'sd0, renc_pkg::BTN_OPEN}},
    '{renc_pkg::REQ_TICK, 1'b0, 1'b0, 1'b0, 1'b0, '{5'sd0, renc_pkg::BTN_OPEN}},
    '{renc_pkg::REQ_VALUE, 1'b1, 1'b1, 1'b0, 1'b0, '{5'sd0, renc_pkg::BTN_OPEN}},
    '{renc_pkg::REQ_BUTTON, 1'b0, 1'b0, 1'b1, 1'b0, '{5'sd0, renc_pkg::BTN_OPEN}},
    '{REQ_UNUSED, 1'b1, 1'b1, 1'b1, 1'b0, '{5'sd0, renc_pkg::BTN_OPEN}}
  };

  // Register settings per random phase. Covers every decoder mode (spare
  // one too), scaling and non-scaling notch codes, both levels, the hold
  // and window extremes, and windows shorter than one button interval.
  localparam phase_cfg_t PHASE_CFG [PHASES] = '{
    '{renc_pkg::MODE_GRAY, 3'd1, 1'b0, 1'b1, 1'b1, 1'b1, 16'd30,    10'd60},
    '{renc_pkg::MODE_FULL, 3'd4, 1'b1, 1'b1, 1'b1, 1'b1, 16'd100,   10'd80},
    '{renc_pkg::MODE_HALF, 3'd2, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0,     10'd1023},
    '{MODE_SPARE,          3'd0, 1'b1, 1'b1, 1'b1, 1'b0, 16'd65535, 10'd9},
    '{renc_pkg::MODE_GRAY, 3'd7, 1'b0, 1'b1, 1'b1, 1'b1, 16'd20,    10'd0},
    '{renc_pkg::MODE_FULL, 3'd3, 1'b1, 1'b0, 1'b1, 1'b0, 16'd40,    10'd120},
    '{renc_pkg::MODE_HALF, 3'd4, 1'b0, 1'b1, 1'b1, 1'b1, 16'd50,    10'd100},
    '{renc_pkg::MODE_GRAY, 3'd2, 1'b1, 1'b1, 1'b1, 1'b1, 16'd30,    10'd70}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  renc_item_if   item_ch ();
  renc_result_if res_ch ();
  renc_cfg_if    cfg_ch ();

  // tb-side drivers, known from time zero
  logic        item_valid = 1'b0;
  logic [1:0]  item_req   = renc_pkg::REQ_TICK;
  logic        item_a     = 1'b1;
  logic        item_b     = 1'b1;
  logic        item_btn   = 1'b1;
  logic        res_ready  = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [2:0]  cfg_index  = renc_pkg::REG_DECODER_MODE;
  logic [15:0] cfg_data   = 16'd0;

  assign item_ch.valid        = item_valid;
  assign item_ch.req_type     = item_req;
  assign item_ch.pin_a        = item_a;
  assign item_ch.pin_b        = item_b;
  assign item_ch.button_level = item_btn;
  assign res_ch.ready         = res_ready;
  assign cfg_ch.valid         = cfg_valid;
  assign cfg_ch.index         = cfg_index;
  assign cfg_ch.data          = cfg_data;

  rotary_encoder_accel_button #(
    .BUTTON_INTERVAL(BTN_IVL)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // ---------------------------------------------------------------------
  // Predictor: register copy and decoder / button state
  // ---------------------------------------------------------------------
  logic [1:0]  m_mode;
  logic [2:0]  m_spn;
  logic        m_act;
  logic        m_acc_en;
  logic        m_dc_en;
  logic        m_held_en;
  logic [15:0] m_hold;
  logic [9:0]  m_dcw;

  logic [3:0]  enc_hist;
  logic [15:0] step_cnt;
  logic [10:0] accel;
  logic [3:0]  tick_div;
  logic [15:0] press_cnt;
  logic [9:0]  dc_timer;
  logic [2:0]  btn_state;

  renc_word_t pending_words [$];
  int err_cnt = 0;

  function automatic void model_reset();
    m_mode    = renc_pkg::MODE_GRAY;
    m_spn     = 3'd1;
    m_act     = 1'b0;
    m_acc_en  = 1'b1;
    m_dc_en   = 1'b1;
    m_held_en = 1'b1;
    m_hold    = 16'd100;
    m_dcw     = 10'd60;
    enc_hist  = '0;
    step_cnt  = '0;
    accel     = '0;
    tick_div  = '0;
    press_cnt = '0;
    dc_timer  = '0;
    btn_state = renc_pkg::BTN_OPEN;
  endfunction

  function automatic void model_config(logic [2:0] idx, logic [15:0] d);
    case (idx)
      renc_pkg::REG_DECODER_MODE:    m_mode    = d[1:0];
      renc_pkg::REG_STEPS_PER_NOTCH: m_spn     = d[2:0];
      renc_pkg::REG_ACTIVE_LEVEL:    m_act     = d[0];
      renc_pkg::REG_ACCEL_ENABLE:    m_acc_en  = d[0];
      renc_pkg::REG_DC_ENABLE:       m_dc_en   = d[0];
      renc_pkg::REG_HELD_ENABLE:     m_held_en = d[0];
      renc_pkg::REG_HOLD_LIMIT:      m_hold    = d;
      renc_pkg::REG_DC_WINDOW:       m_dcw     = d[9:0];
      default: ;
    endcase
  endfunction

  // returns 1 when the count moved
  function automatic bit decode_move(logic a_on, logic b_on);
    logic [1:0] cur;
    logic [1:0] diff;
    int         d;
    if (m_mode == renc_pkg::MODE_FULL || m_mode == renc_pkg::MODE_HALF) begin
      enc_hist = {enc_hist[1:0], a_on, b_on};
      d = (m_mode == renc_pkg::MODE_FULL) ? FULL_DIR[enc_hist] : HALF_DIR[enc_hist];
      if (d == 0) return 1'b0;
      step_cnt = (d > 0) ? step_cnt + 16'd1 : step_cnt - 16'd1;
      return 1'b1;
    end
    // gray rule: phase number from the pin pair, only low history bits count
    cur  = {a_on, a_on ^ b_on};
    diff = enc_hist[1:0] - cur;
    if (!diff[0]) return 1'b0;
    enc_hist = {2'b00, cur};
    step_cnt = diff[1] ? step_cnt + 16'd1 : step_cnt - 16'd1;
    return 1'b1;
  endfunction

  // one button check, every BTN_IVL ticks
  function automatic void button_scan(logic pressed);
    logic [9:0] win;
    win = 10'(m_dcw / BTN_IVL);
    if (pressed) begin
      if (press_cnt != 16'hFFFF) press_cnt = press_cnt + 16'd1;
      if (press_cnt > m_hold / BTN_IVL && m_held_en) btn_state = renc_pkg::BTN_HELD;
    end else begin
      if (press_cnt > 16'd1) begin
        if (btn_state == renc_pkg::BTN_HELD) begin
          btn_state = renc_pkg::BTN_RELEASED;
          dc_timer  = '0;
        end else if (dc_timer > 10'd1) begin
          if (dc_timer < win) begin
            btn_state = renc_pkg::BTN_DOUBLE;
            dc_timer  = '0;
          end
        end else begin
          dc_timer = m_dc_en ? win : 10'd1;
        end
      end
      press_cnt = '0;
    end
    if (dc_timer != 10'd0) begin
      dc_timer = dc_timer - 10'd1;
      if (dc_timer == 10'd0) btn_state = renc_pkg::BTN_CLICKED;
    end
  endfunction

  // advances the state by one accepted word; 1 when a result word follows
  function automatic bit predict_word(logic [1:0] req, logic a, logic b, logic btn,
                                      output renc_word_t w);
    bit          moved;
    logic [15:0] cnt;
    logic [3:0]  mag;
    int          shift;
    w = '0;
    case (req)
      renc_pkg::REQ_TICK: begin
        if (m_acc_en) begin
          accel = (accel >= renc_pkg::ACCEL_DEC) ? accel - renc_pkg::ACCEL_DEC : 11'd0;
        end
        moved = decode_move(a == m_act, b == m_act);
        if (m_acc_en && moved && accel <= renc_pkg::ACCEL_TOP - renc_pkg::ACCEL_INC) begin
          accel = accel + renc_pkg::ACCEL_INC;
        end
        tick_div = tick_div + 4'd1;
        if (tick_div >= BTN_IVL) begin
          tick_div = '0;
          button_scan(btn == m_act);
        end
        return 1'b0;
      end
      renc_pkg::REQ_VALUE: begin
        cnt   = step_cnt;
        shift = 0;
        if (m_spn == renc_pkg::SPN_TWO) begin
          step_cnt = cnt & 16'd1;
          shift    = 1;
        end else if (m_spn == renc_pkg::SPN_FOUR) begin
          step_cnt = cnt & 16'd3;
          shift    = 2;
        end else begin
          step_cnt = '0;
        end
        mag = 4'd1 + (m_acc_en ? 4'(accel >> 8) : 4'd0);
        // a negative count reads as at least one step down, whatever the shift
        if (cnt[15]) w.rotation = 5'd0 - {1'b0, mag};
        else if ((cnt >> shift) != 16'd0) w.rotation = {1'b0, mag};
        return 1'b1;
      end
      renc_pkg::REQ_BUTTON: begin
        w.status = btn_state;
        if (btn_state != renc_pkg::BTN_HELD && btn_state != renc_pkg::BTN_OPEN) begin
          btn_state = renc_pkg::BTN_OPEN;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request, checking
  // ---------------------------------------------------------------------
  logic [7:0] hog_req  = '0;   // bumped by the sender to ask for a hold-off
  logic [7:0] hog_seen = '0;
  int         hog_left = 0;
  int         stall_left = 0;
  bit         calm = 1'b0;     // last phase: no idling on either side

  always @(posedge clk) begin : result_sink
    renc_word_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ready) begin
        if (pending_words.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected word, rotation %0d status %0d", $time,
                   res_ch.rotation_value, res_ch.button_status);
        end else begin
          want = pending_words.pop_front();
          if (res_ch.rotation_value !== want.rotation) begin
            err_cnt++;
            $display("%0t: rotation_value expected %0d actual %0d", $time,
                     want.rotation, res_ch.rotation_value);
          end
          if (res_ch.button_status !== want.status) begin
            err_cnt++;
            $display("%0t: button_status expected %0d actual %0d", $time,
                     want.status, res_ch.button_status);
          end
        end
      end
      if (hog_seen != hog_req) begin
        hog_seen  <= hog_req;
        hog_left  <= HOG_CYCLES - 1;
        res_ready <= 1'b0;
      end else if (hog_left > 0) begin
        hog_left  <= hog_left - 1;
        res_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        res_ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 15) begin
        stall_left <= $urandom_range(0, 13);  // random stall burst
        res_ready  <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: cycles in which no word moves on any channel
  // ---------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (item_valid && item_ch.ready) || (res_ch.valid && res_ready) ||
        (cfg_valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // offer one input word, update the predictor when it is taken
  task automatic send_word(logic [1:0] req, logic a, logic b, logic btn, bit may_idle,
                           bit typed, renc_word_t typed_w);
    renc_word_t w;
    bit         has;
    if (may_idle && !calm && $urandom_range(0, 99) < 12) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_req   <= req;
    item_a     <= a;
    item_b     <= b;
    item_btn   <= btn;
    do @(posedge clk); while (!item_ch.ready);
    has = predict_word(req, a, b, btn, w);
    if (has) pending_words.push_back(typed ? typed_w : w);
  endtask

  // stop offering and let every expected word come out, plus pipeline slack
  task automatic wait_quiet();
    item_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    model_config(idx, d);
  endtask

  task automatic program_phase(phase_cfg_t s);
    wait_quiet();
    write_reg(renc_pkg::REG_DECODER_MODE,    16'(s.mode));
    write_reg(renc_pkg::REG_STEPS_PER_NOTCH, 16'(s.spn));
    write_reg(renc_pkg::REG_ACTIVE_LEVEL,    16'(s.act));
    write_reg(renc_pkg::REG_ACCEL_ENABLE,    16'(s.acc_en));
    write_reg(renc_pkg::REG_DC_ENABLE,       16'(s.dc_en));
    write_reg(renc_pkg::REG_HELD_ENABLE,     16'(s.held_en));
    write_reg(renc_pkg::REG_HOLD_LIMIT,      s.hold);
    write_reg(renc_pkg::REG_DC_WINDOW,       16'(s.dcw));
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // Random stream: mostly ticks that walk the encoder along valid phase
  // sequences in segments (fast spins build up accel), with some glitches,
  // and a button that goes through short presses, long holds and gaps.
  logic [1:0] gen_pos    = 2'd0;
  bit         spin_up    = 1'b1;
  int         spin_left  = 0;
  int         spin_speed = 0;
  bit         btn_on     = 1'b0;
  int         btn_left   = 0;

  task automatic next_random(output logic [1:0] req, output logic a, output logic b,
                             output logic btn);
    int   r;
    logic on_a;
    logic on_b;
    r   = $urandom_range(0, 99);
    a   = 1'($urandom_range(0, 1));
    b   = 1'($urandom_range(0, 1));
    btn = 1'($urandom_range(0, 1));
    if (r < 2) req = REQ_UNUSED;
    else if (r < 8) req = renc_pkg::REQ_VALUE;
    else if (r < 12) req = renc_pkg::REQ_BUTTON;
    else req = renc_pkg::REQ_TICK;
    if (req == renc_pkg::REQ_TICK) begin
      if (spin_left == 0) begin
        spin_up = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0: begin spin_speed = 100; spin_left = $urandom_range(60, 160); end
          1: begin spin_speed = 70;  spin_left = $urandom_range(10, 40); end
          2: begin spin_speed = 25;  spin_left = $urandom_range(10, 40); end
          default: begin spin_speed = 0; spin_left = $urandom_range(5, 30); end
        endcase
      end
      spin_left--;
      if ($urandom_range(0, 99) < spin_speed) gen_pos = spin_up ? gen_pos + 2'd1 : gen_pos - 2'd1;
      on_a = gen_pos[1];
      on_b = gen_pos[1] ^ gen_pos[0];
      if ($urandom_range(0, 99) < 4) begin  // contact bounce
        on_a = 1'($urandom_range(0, 1));
        on_b = 1'($urandom_range(0, 1));
      end
      if (btn_left == 0) begin
        btn_on = !btn_on;
        if (btn_on) btn_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                                           : $urandom_range(12, 35);
        else btn_left = $urandom_range(4, 40);
      end
      btn_left--;
      // map active levels onto pin levels for the current polarity
      a   = ~(on_a ^ m_act);
      b   = ~(on_b ^ m_act);
      btn = ~(btn_on ^ m_act);
    end
  endtask

  initial begin
    int         n;
    logic [1:0] rq;
    logic       pa;
    logic       pb;
    logic       pbtn;
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    for (int i = 0; i < STIM_ROWS; i++) begin
      send_word(STIM_TAB[i].req, STIM_TAB[i].pin_a, STIM_TAB[i].pin_b, STIM_TAB[i].btn,
                1'b1, STIM_TAB[i].typed, STIM_TAB[i].word);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      program_phase(PHASE_CFG[p]);
      if (p == PHASES - 1) calm <= 1'b1;
      n = 0;
      while (n < RAND_PER_PHASE) begin
        if (p == HOG_PHASE && n == RAND_PER_PHASE / 2) begin
          // long receiver hold-off while reads keep coming: fills the block
          hog_req <= hog_req + 8'd1;
          repeat (HOG_BURST) begin
            rq = $urandom_range(0, 1) ? renc_pkg::REQ_VALUE : renc_pkg::REQ_BUTTON;
            send_word(rq, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
            n++;
          end
        end
        next_random(rq, pa, pb, pbtn);
        send_word(rq, pa, pb, pbtn, 1'b1, 1'b0, '0);
        if (rq != REQ_UNUSED) n++;
      end
    end

    item_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
